// ----- hw/rtl/lpmr_pkg.sv -----
`timescale 1ns / 1ps

package lpmr_pkg;

	// Default sizing of the ring.
	localparam int BUFFER_BYTES_DEF = 4096;
	localparam int LEN_BYTES_DEF    = 4;

	// Field widths that the channels fix.
	localparam int KIND_W   = 2;
	localparam int LENGTH_W = 13;
	localparam int HEADER_W = 64;
	localparam int BYTE_W   = 8;
	localparam int STATUS_W = 2;
	localparam int HCFG_W   = 4;

	// Operation codes on the input channel.
	localparam logic [KIND_W-1:0] KIND_BEGIN_WRITE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_WRITE_BYTE  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_READ_HEADER = 2'd2;
	localparam logic [KIND_W-1:0] KIND_READ_BYTE   = 2'd3;

	// Status codes on the output channel.
	localparam logic [STATUS_W-1:0] STS_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STS_NO_SPACE = 2'd1;
	localparam logic [STATUS_W-1:0] STS_NO_MSG   = 2'd2;
	localparam logic [STATUS_W-1:0] STS_IGNORED  = 2'd3;

	// One result item.
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [HEADER_W-1:0] header_out;
		logic [LENGTH_W-1:0] body_length_out;
		logic [LENGTH_W-1:0] return_length;
		logic [BYTE_W-1:0]   data_out;
		logic                last;
	} res_t;

endpackage

// ----- hw/rtl/lpmr_ram.sv -----
`timescale 1ns / 1ps

module lpmr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- hw/rtl/lpmr_ctrl.sv -----
`timescale 1ns / 1ps

module lpmr_ctrl #(
	parameter int BUFFER_BYTES = lpmr_pkg::BUFFER_BYTES_DEF,
	parameter int LEN_BYTES    = lpmr_pkg::LEN_BYTES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [lpmr_pkg::HCFG_W-1:0]       cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [lpmr_pkg::KIND_W-1:0]       kind,
	input  logic [lpmr_pkg::LENGTH_W-1:0]     body_length,
	input  logic [lpmr_pkg::HEADER_W-1:0]     header_value,
	input  logic [lpmr_pkg::BYTE_W-1:0]       data_byte,
	input  logic [lpmr_pkg::LENGTH_W-1:0]     read_limit,
	output logic                              res_valid,
	input  logic                              res_ready,
	output lpmr_pkg::res_t                    res,
	output logic                              mem_we,
	output logic [$clog2(BUFFER_BYTES)-1:0]   mem_waddr,
	output logic [lpmr_pkg::BYTE_W-1:0]       mem_wdata,
	output logic                              mem_re,
	output logic [$clog2(BUFFER_BYTES)-1:0]   mem_raddr,
	input  logic [lpmr_pkg::BYTE_W-1:0]       mem_rdata
);

	localparam int AW   = $clog2(BUFFER_BYTES);
	localparam int PW   = AW + 1;
	localparam int SPAN = 2 * BUFFER_BYTES;
	localparam int CW   = ((PW > 14) ? PW : 14) + 1;
	localparam int NSZ  = (LEN_BYTES < 2) ? LEN_BYTES : 2;
	localparam int WCW  = $clog2(LEN_BYTES + 16);
	localparam int TW   = $clog2(NSZ + 9);
	localparam int LW   = lpmr_pkg::LENGTH_W;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_WHDR  = 6'b000010,
		ST_RWALK = 6'b000100,
		ST_RCHK  = 6'b001000,
		ST_RBYTE = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t                      state_q;
	logic [lpmr_pkg::HCFG_W-1:0] hdr_bytes_q;
	logic [PW-1:0]               wpos_q;
	logic [PW-1:0]               rpos_q;
	logic [LW-1:0]               wleft_q;
	logic [LW-1:0]               rleft_q;
	logic [LW-1:0]               skip_q;
	logic [WCW-1:0]              wcnt_q;
	logic [TW-1:0]               widx_q;
	logic                        rvld_s1;
	logic [TW-1:0]               rtag_s1;
	logic [LW-1:0]               blen_q;
	logic [lpmr_pkg::HEADER_W-1:0] hval_q;
	logic [LW-1:0]               limit_q;
	logic [15:0]                 size_acc_q;
	logic [lpmr_pkg::HEADER_W-1:0] hdr_acc_q;
	lpmr_pkg::res_t              res_q;

	logic          accept;
	logic [PW:0]   diff;
	logic [PW:0]   used_raw;
	logic [CW-1:0] used_c;
	logic [CW-1:0] avail;
	logic [CW-1:0] need_w;
	logic [CW-1:0] fixed_w;
	logic [CW-1:0] need_r;
	logic [LW-1:0] size_w;
	logic [LW-1:0] ret_w;
	logic          too_long;
	logic [3:0]    hn;
	logic [TW-1:0] total_w;
	logic          issue;
	logic [CW-1:0] walk_off;
	logic [WCW-1:0] wend;
	logic [WCW-1:0] hsel_w;
	logic [15:0]   blen16;
	logic [7:0]    hdr_byte;
	logic [PW-1:0] wpos_inc;
	logic [TW-1:0] hsel_r;

	// Store index of a ring position (positions run over twice the capacity).
	function automatic logic [AW-1:0] store_idx(input logic [PW-1:0] p);
		logic [PW-1:0] t;
		begin
			t = (p >= PW'(BUFFER_BYTES)) ? (p - PW'(BUFFER_BYTES)) : p;
			return t[AW-1:0];
		end
	endfunction

	// Ring position advanced by at most one span.
	function automatic logic [PW-1:0] pos_add(input logic [PW-1:0] p, input logic [CW-1:0] n);
		logic [CW:0] s;
		begin
			s = (CW+1)'(p) + (CW+1)'(n);
			if (s >= (CW+1)'(SPAN)) begin
				s = s - (CW+1)'(SPAN);
			end
			return s[PW-1:0];
		end
	endfunction

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign res_valid = (state_q == ST_DONE);
	assign res       = res_q;

	// Fill level and space checks.
	always_comb begin
		diff     = {1'b0, wpos_q} - {1'b0, rpos_q};
		used_raw = diff[PW] ? (diff + (PW+1)'(SPAN)) : diff;
		used_c   = (used_raw > (PW+1)'(BUFFER_BYTES)) ? CW'(BUFFER_BYTES) : CW'(used_raw);
		avail    = CW'(BUFFER_BYTES) - used_c;
		fixed_w  = CW'(LEN_BYTES) + CW'(hdr_bytes_q);
		need_w   = fixed_w + CW'(body_length);
		size_w   = size_acc_q[LW-1:0];
		need_r   = fixed_w + CW'(size_w);
		ret_w    = (size_w < limit_q) ? size_w : limit_q;
		too_long = (LEN_BYTES == 1) && (body_length[LW-1:8] != '0);
	end

	// Header walk: prefix bytes that carry the length, then up to eight header bytes.
	always_comb begin
		hn       = (hdr_bytes_q > 4'd8) ? 4'd8 : hdr_bytes_q;
		total_w  = TW'(NSZ) + TW'(hn);
		issue    = (state_q == ST_RWALK) && (widx_q != total_w);
		if (widx_q < TW'(NSZ)) begin
			walk_off = CW'(widx_q);
		end else begin
			walk_off = CW'(LEN_BYTES) + CW'(widx_q) - CW'(NSZ);
		end
		hsel_r   = rtag_s1 - TW'(NSZ);
	end

	// Byte to write while laying down the prefix and the header.
	always_comb begin
		wend     = WCW'(LEN_BYTES) + WCW'(hdr_bytes_q) - WCW'(1);
		hsel_w   = wcnt_q - WCW'(LEN_BYTES);
		blen16   = {3'b000, blen_q};
		if (wcnt_q < WCW'(LEN_BYTES)) begin
			hdr_byte = (wcnt_q < WCW'(2)) ? blen16[{wcnt_q[0], 3'b000} +: 8] : 8'd0;
		end else begin
			hdr_byte = (hsel_w < WCW'(8)) ? hval_q[{hsel_w[2:0], 3'b000} +: 8] : 8'd0;
		end
		wpos_inc = pos_add(wpos_q, CW'(1));
	end

	// Memory port control.
	always_comb begin
		mem_we    = (state_q == ST_WHDR) ||
			(accept && (kind == lpmr_pkg::KIND_WRITE_BYTE) && (wleft_q != '0));
		mem_waddr = store_idx(wpos_q);
		mem_wdata = (state_q == ST_WHDR) ? hdr_byte : data_byte;
		mem_re    = issue ||
			(accept && (kind == lpmr_pkg::KIND_READ_BYTE) && (rleft_q != '0));
		mem_raddr = store_idx(pos_add(rpos_q, (state_q == ST_RWALK) ? walk_off : '0));
	end

	// Control state, positions and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			hdr_bytes_q <= '0;
			wpos_q      <= '0;
			rpos_q      <= '0;
			wleft_q     <= '0;
			rleft_q     <= '0;
			skip_q      <= '0;
			wcnt_q      <= '0;
			widx_q      <= '0;
			rvld_s1     <= 1'b0;
		end else begin
			if (cfg_we) begin
				hdr_bytes_q <= cfg_wdata;
			end
			rvld_s1 <= issue;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (kind)
							lpmr_pkg::KIND_BEGIN_WRITE: begin
								if (wleft_q != '0 || too_long || need_w > avail) begin
									state_q <= ST_DONE;
								end else begin
									wleft_q <= body_length;
									wcnt_q  <= '0;
									state_q <= ST_WHDR;
								end
							end
							lpmr_pkg::KIND_WRITE_BYTE: begin
								if (wleft_q != '0) begin
									wpos_q  <= wpos_inc;
									wleft_q <= wleft_q - LW'(1);
								end
								state_q <= ST_DONE;
							end
							lpmr_pkg::KIND_READ_HEADER: begin
								if (rleft_q == '0 && used_c >= CW'(LEN_BYTES)) begin
									widx_q  <= '0;
									state_q <= ST_RWALK;
								end else begin
									state_q <= ST_DONE;
								end
							end
							lpmr_pkg::KIND_READ_BYTE: begin
								state_q <= (rleft_q != '0) ? ST_RBYTE : ST_DONE;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_WHDR: begin
					wpos_q <= wpos_inc;
					wcnt_q <= wcnt_q + WCW'(1);
					if (wcnt_q == wend) begin
						state_q <= ST_DONE;
					end
				end
				ST_RWALK: begin
					if (issue) begin
						widx_q <= widx_q + TW'(1);
					end else begin
						state_q <= ST_RCHK;
					end
				end
				ST_RCHK: begin
					if (used_c >= need_r) begin
						if (ret_w == '0) begin
							rpos_q <= pos_add(rpos_q, need_r);
						end else begin
							rpos_q  <= pos_add(rpos_q, fixed_w);
							rleft_q <= ret_w;
							skip_q  <= size_w - ret_w;
						end
					end
					state_q <= ST_DONE;
				end
				ST_RBYTE: begin
					rleft_q <= rleft_q - LW'(1);
					if (rleft_q == LW'(1)) begin
						rpos_q <= pos_add(rpos_q, CW'(skip_q) + CW'(1));
						skip_q <= '0;
					end else begin
						rpos_q <= pos_add(rpos_q, CW'(1));
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Captured fields, gathered header bytes and the result under construction.
	always_ff @(posedge clk) begin
		rtag_s1 <= widx_q;
		if (rvld_s1) begin
			if (rtag_s1 < TW'(NSZ)) begin
				size_acc_q[{rtag_s1[0], 3'b000} +: 8] <= mem_rdata;
			end else begin
				hdr_acc_q[{hsel_r[2:0], 3'b000} +: 8] <= mem_rdata;
			end
		end
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					blen_q     <= body_length;
					hval_q     <= header_value;
					limit_q    <= read_limit;
					size_acc_q <= '0;
					hdr_acc_q  <= '0;
					res_q      <= '0;
					case (kind)
						lpmr_pkg::KIND_BEGIN_WRITE: begin
							if (wleft_q != '0) begin
								res_q.status <= lpmr_pkg::STS_IGNORED;
							end else if (too_long || need_w > avail) begin
								res_q.status <= lpmr_pkg::STS_NO_SPACE;
							end
						end
						lpmr_pkg::KIND_WRITE_BYTE: begin
							if (wleft_q == '0) begin
								res_q.status <= lpmr_pkg::STS_IGNORED;
							end
						end
						lpmr_pkg::KIND_READ_HEADER: begin
							if (rleft_q != '0) begin
								res_q.status <= lpmr_pkg::STS_IGNORED;
							end else if (used_c < CW'(LEN_BYTES)) begin
								res_q.status <= lpmr_pkg::STS_NO_MSG;
							end
						end
						lpmr_pkg::KIND_READ_BYTE: begin
							if (rleft_q == '0) begin
								res_q.status <= lpmr_pkg::STS_IGNORED;
							end
						end
						default: begin
							res_q.status <= lpmr_pkg::STS_IGNORED;
						end
					endcase
				end
			end
			ST_RCHK: begin
				if (used_c < need_r) begin
					res_q.status <= lpmr_pkg::STS_NO_MSG;
				end else begin
					res_q.header_out      <= hdr_acc_q;
					res_q.body_length_out <= size_w;
					res_q.return_length   <= ret_w;
				end
			end
			ST_RBYTE: begin
				res_q.data_out <= mem_rdata;
				res_q.last     <= (rleft_q == LW'(1));
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- hw/rtl/length_prefixed_message_ring_core.sv -----
`timescale 1ns / 1ps

// Ring of messages, each framed as a little-endian length prefix, a header of
// header_bytes bytes and a body. header_bytes is written on cfg_we; the user
// writes it only while idle, which the block itself does not enforce.
// The input channel (in_valid/in_ready) carries one command per transfer:
// begin write, write body byte, read header or read body byte. Every command
// yields exactly one result transfer on out_valid/out_ready, in order.
// A command is taken only when the previous one has finished its work in the
// store; the result sits in an output register, so the next command is taken
// while a result still waits for the receiver.
// A begin write makes one store write per prefix or header byte, and a read
// header makes one store read per byte through the registered read port, for
// min(LEN_BYTES, 2) prefix bytes and min(header_bytes, 8) header bytes.
// A stalled receiver holds the result in the output register; one more
// command can finish behind it, after which in_ready stays low.
// Reset empties the ring and clears header_bytes; the store itself is not
// cleared, and no byte is read before it was written.
module length_prefixed_message_ring_core #(
	parameter int BUFFER_BYTES = lpmr_pkg::BUFFER_BYTES_DEF,
	parameter int LEN_BYTES    = lpmr_pkg::LEN_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [lpmr_pkg::HCFG_W-1:0]   cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [lpmr_pkg::KIND_W-1:0]   kind,
	input  logic [lpmr_pkg::LENGTH_W-1:0] body_length,
	input  logic [lpmr_pkg::HEADER_W-1:0] header_value,
	input  logic [lpmr_pkg::BYTE_W-1:0]   data_byte,
	input  logic [lpmr_pkg::LENGTH_W-1:0] read_limit,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [lpmr_pkg::STATUS_W-1:0] status,
	output logic [lpmr_pkg::HEADER_W-1:0] header_out,
	output logic [lpmr_pkg::LENGTH_W-1:0] body_length_out,
	output logic [lpmr_pkg::LENGTH_W-1:0] return_length,
	output logic [lpmr_pkg::BYTE_W-1:0]   data_out,
	output logic                          last
);

	localparam int AW = $clog2(BUFFER_BYTES);

	logic                        res_valid;
	logic                        res_ready;
	lpmr_pkg::res_t              res;
	logic                        mem_we;
	logic [AW-1:0]               mem_waddr;
	logic [lpmr_pkg::BYTE_W-1:0] mem_wdata;
	logic                        mem_re;
	logic [AW-1:0]               mem_raddr;
	logic [lpmr_pkg::BYTE_W-1:0] mem_rdata;
	logic                        out_valid_q;
	lpmr_pkg::res_t              out_q;

	lpmr_ctrl #(
		.BUFFER_BYTES (BUFFER_BYTES),
		.LEN_BYTES    (LEN_BYTES)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.body_length  (body_length),
		.header_value (header_value),
		.data_byte    (data_byte),
		.read_limit   (read_limit),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res          (res),
		.mem_we       (mem_we),
		.mem_waddr    (mem_waddr),
		.mem_wdata    (mem_wdata),
		.mem_re       (mem_re),
		.mem_raddr    (mem_raddr),
		.mem_rdata    (mem_rdata)
	);

	lpmr_ram #(
		.WIDTH (lpmr_pkg::BYTE_W),
		.DEPTH (BUFFER_BYTES)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Output register: takes a finished result whenever it is empty or drains.
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = out_q.status;
	assign header_out      = out_q.header_out;
	assign body_length_out = out_q.body_length_out;
	assign return_length   = out_q.return_length;
	assign data_out        = out_q.data_out;
	assign last            = out_q.last;

endmodule
